FILE: design/dsi_manchester_frame_transmitter_unit_defines.svh
// ----------------------------------------------------------------------------
// DSI Manchester frame transmitter assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DSI_MANCHESTER_FRAME_TRANSMITTER_UNIT_DEFINES_SVH
`define DSI_MANCHESTER_FRAME_TRANSMITTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check a property on every rising clock edge, ignored while in reset
`define DMFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising clock edge, reset included
`define DMFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMFT_ASSERT(lbl, prop, msg)
`define DMFT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/dmft_pkg.sv
// ----------------------------------------------------------------------------
// DSI Manchester frame transmitter package
// Shared phase codes, register indexes, reset values and bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package dmft_pkg;

  // Field and register widths
  localparam int LEN_W     = 8;
  localparam int LEVEL_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Default tick counter width
  localparam int COUNT_WIDTH_DEF = 8;

  // Phase lengths
  localparam int START_TICKS = 1;
  localparam int DATA_TICKS  = 16;

  // Register reset values
  localparam logic [LEN_W-1:0] PAUSE_RESET = 8'd79;
  localparam logic [LEN_W-1:0] END_RESET   = 8'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LENGTH   = 1'b1;

  // Frame phases
  typedef enum logic [1:0] {
    PHASE_PAUSE = 2'd0,
    PHASE_START = 2'd1,
    PHASE_DATA  = 2'd2,
    PHASE_END   = 2'd3
  } phase_t;

  // Phase lengths as held by the register bank
  typedef struct packed {
    logic [LEN_W-1:0] pause_length;
    logic [LEN_W-1:0] end_length;
  } cfg_t;

  // One tick's result
  typedef struct packed {
    logic   line_level;
    phase_t phase;
  } result_t;

endpackage

`default_nettype wire

FILE: design/dmft_cfg_regs.sv
// ----------------------------------------------------------------------------
// DSI Manchester frame transmitter register bank
// Holds the pause and end lengths written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmft_cfg_regs
  import dmft_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  cfg_t regs;

  // Take a write at the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pause_length <= PAUSE_RESET;
      regs.end_length   <= END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAUSE_LENGTH: regs.pause_length <= cfg_data;
        CFG_END_LENGTH:   regs.end_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

FILE: design/dmft_sequencer.sv
// ----------------------------------------------------------------------------
// DSI Manchester frame transmitter phase sequencer
// Tracks phase and tick count and forms the line level of each tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dmft_sequencer
  import dmft_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               advance,
  input  wire logic [LEVEL_W-1:0] level,
  output result_t                 result
);

  localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  phase_t                   phase_reg;
  logic [COUNT_WIDTH-1:0]   tick_count;
  logic [LEVEL_W-1:0]       data_byte;

  phase_t                   phase_cur;
  logic [COUNT_WIDTH-1:0]   count_cur;
  logic [LEVEL_W-1:0]       byte_cur;
  logic [CMP_W-1:0]         len_sel;
  logic                     at_end;
  logic [3:0]               half_idx;
  logic                     data_bit;

  // Pick the length of the current phase
  always_comb begin
    case (phase_reg)
      PHASE_PAUSE: len_sel = CMP_W'(cfg.pause_length);
      PHASE_START: len_sel = CMP_W'(START_TICKS);
      PHASE_DATA:  len_sel = CMP_W'(DATA_TICKS);
      PHASE_END:   len_sel = CMP_W'(cfg.end_length);
      default:     len_sel = CMP_W'(cfg.end_length);
    endcase
  end

  // A saturated counter also closes the phase: lengths are capped at its max
  assign at_end = (CMP_W'(tick_count) >= len_sel) || (tick_count == CNT_MAX);

  // Step to the next phase; latch the byte when entering data
  always_comb begin
    phase_cur = at_end ? phase_t'(phase_reg + 2'd1) : phase_reg;
    count_cur = at_end ? '0 : tick_count;
    byte_cur  = (at_end && phase_cur == PHASE_DATA) ? level : data_byte;
  end

  // Manchester half-bit: MSB first, a one as high then low
  assign half_idx = count_cur[3:0];
  assign data_bit = byte_cur[3'd7 - half_idx[3:1]];

  always_comb begin
    result.phase = phase_cur;
    case (phase_cur)
      PHASE_START: result.line_level = 1'b1;
      PHASE_DATA:  result.line_level = data_bit ^ half_idx[0];
      default:     result.line_level = 1'b0;
    endcase
  end

  // Commit state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg  <= PHASE_PAUSE;
      tick_count <= '0;
    end else if (advance) begin
      phase_reg  <= phase_cur;
      tick_count <= (count_cur == CNT_MAX) ? count_cur : count_cur + COUNT_WIDTH'(1);
    end
  end

  // Hold the latched byte
  always_ff @(posedge clk) begin
    if (advance) begin
      data_byte <= byte_cur;
    end
  end

endmodule

`default_nettype wire

FILE: design/dmft_out_stage.sv
// ----------------------------------------------------------------------------
// DSI Manchester frame transmitter output stage
// Result register that parts the input side from the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dmft_out_stage
  import dmft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire result_t    result,
  input  wire logic       m_tready,
  output logic            m_tvalid,
  output logic [7:0]      m_tdata,
  output logic [1:0]      m_tuser,
  output logic            room
);

  logic    out_valid;
  result_t out_data;

  // Room for a new result when empty or when the current one transfers
  assign room = !out_valid || m_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load && room) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_data.line_level};
  assign m_tuser  = out_data.phase;

endmodule

`default_nettype wire

FILE: design/dsi_manchester_frame_transmitter_unit.sv
// An accepted tick shows its line level on m_tdata in the next cycle, from the output result register.
// Throughput: one tick per cycle while m_tready is high, set by the single result register in the output stage.
// A stalled output holds the result and blocks input only while it stays untaken.
// Reset (rst, synchronous): pause phase, tick count zero, lengths 79 and 4, output empty.
// ----------------------------------------------------------------------------
// DSI Manchester frame transmitter
// Turns bit-period ticks into line levels of pause, start, data and end phases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dsi_manchester_frame_transmitter_unit_defines.svh"

module dsi_manchester_frame_transmitter_unit
  import dmft_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Tick input
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] level
  // Line level output
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,   // [0] line_level, [7:1] zero
  output logic [1:0]                m_tuser,   // [1:0] phase
  // Register writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data
);

  cfg_t    cfg;
  result_t result;
  logic    room;
  logic    in_xfer;

  // Accept a tick whenever the result register can take it
  assign s_tready = room;
  assign in_xfer  = s_tvalid && room;

  dmft_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dmft_sequencer #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_sequencer (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (in_xfer),
    .level   (s_tdata),
    .result  (result)
  );

  dmft_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (in_xfer),
    .result   (result),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .room     (room)
  );

  // Start tick drives high, pause and end drive low
  `DMFT_ASSERT(a_start_high, m_tvalid && m_tuser == PHASE_START |-> m_tdata[0], "start tick low")
  `DMFT_ASSERT(a_idle_low, m_tvalid && (m_tuser == PHASE_PAUSE || m_tuser == PHASE_END) |-> !m_tdata[0], "idle tick high")
  // The tick after a start tick is always data
  `DMFT_ASSERT(a_start_one_tick, s_tvalid && s_tready && m_tvalid && m_tuser == PHASE_START |=> m_tuser == PHASE_DATA, "start lasted more than one tick")
  // No result appears out of reset
  `DMFT_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")

endmodule

`default_nettype wire
